// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/bfhcv_pkg.sv
// shared types and constants of the coincidence veto block
// no dependencies
package bfhcv_pkg;

  localparam int COUNT_BITS = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [QPTR_BITS-1:0]  qptr_t;
  typedef logic [QCNT_BITS-1:0]  qcnt_t;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_FLASH = 2'd1,
    KIND_HIT   = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BEAM_START    = 3'd0,
    REG_BEAM_END      = 3'd1,
    REG_PE_MIN        = 3'd2,
    REG_DT_OFFSET     = 3'd3,
    REG_RESOLUTION    = 3'd4,
    REG_USE_AS_FILTER = 3'd5,
    REG_PLANE_ENABLE  = 3'd6
  } reg_idx_t;

  localparam logic signed [27:0] NO_FLASH_TIME = -28'sd10000000;
  localparam logic [32:0]        START_ABS_DT  = 33'd100000000;

  typedef struct packed {
    logic signed [27:0] beam_start_ns;
    logic signed [27:0] beam_end_ns;
    logic [19:0]        pe_min;
    logic signed [27:0] dt_offset_ns;
    logic [26:0]        resolution_ns;
    logic               use_as_filter;
    logic [3:0]         plane_enable;
  } cfg_t;

  // classified request as it travels through the queue
  typedef struct packed {
    kind_t              kind;
    logic               flash_ok;
    logic               hit_en;
    logic signed [27:0] flash_time;
    logic [19:0]        pe;
    logic signed [32:0] rel_time;
    logic signed [20:0] pos_x;
    logic signed [20:0] pos_y;
    logic signed [20:0] pos_z;
  } op_t;

  typedef struct packed {
    logic  full;
    logic  empty;
    qcnt_t count;
  } qstat_t;

  typedef struct packed {
    logic               pass_event;
    logic               coinc_match;
    logic [15:0]        flashes_passing;
    logic signed [27:0] best_flash_time;
    logic [19:0]        best_flash_pe;
    logic signed [32:0] closest_dt;
    logic signed [32:0] closest_hit_time;
    logic [19:0]        matched_pe;
    logic signed [20:0] matched_x;
    logic signed [20:0] matched_y;
    logic signed [20:0] matched_z;
    logic [15:0]        hits_seen;
  } res_t;

endpackage

// File: rtl/bfhcv_front.sv
// front end: accepts requests, tracks event gps time and classifies each request
// depends on bfhcv_pkg
module bfhcv_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  input  logic [1:0]          s_user,
  input  logic [119:0]        s_data,
  output logic                s_ready,
  input  bfhcv_pkg::cfg_t     cfg,
  input  bfhcv_pkg::qstat_t   qstat,
  output logic                push,
  output bfhcv_pkg::op_t      op
);

  logic [29:0]        gps_ns;
  bfhcv_pkg::kind_t   kind;
  logic signed [30:0] t;
  logic [19:0]        pe;
  logic [1:0]         plane;
  logic signed [32:0] rel;

  assign kind  = bfhcv_pkg::kind_t'(s_user);
  assign t     = s_data[30:0];
  assign pe    = s_data[50:31];
  assign plane = s_data[52:51];

  assign s_ready = !qstat.full;
  assign push    = s_valid && s_ready;

  // hit time relative to the event, offset applied
  assign rel = 33'(t) - $signed({3'b000, gps_ns}) + 33'(cfg.dt_offset_ns);

  always_comb begin
    op            = '0;
    op.kind       = kind;
    op.flash_ok   = (t >= 31'(cfg.beam_start_ns)) && (t <= 31'(cfg.beam_end_ns)) &&
                    (pe >= cfg.pe_min);
    op.hit_en     = cfg.plane_enable[plane];
    op.flash_time = t[27:0];
    op.pe         = pe;
    op.rel_time   = rel;
    op.pos_x      = s_data[73:53];
    op.pos_y      = s_data[94:74];
    op.pos_z      = s_data[115:95];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gps_ns <= '0;
    end else if (push && kind == bfhcv_pkg::KIND_START) begin
      gps_ns <= s_data[29:0];
    end
  end

endmodule

// File: rtl/bfhcv_queue.sv
// short queue of classified requests between front and back end
// depends on bfhcv_pkg
module bfhcv_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bfhcv_pkg::op_t    wr_op,
  input  logic              pop,
  output bfhcv_pkg::op_t    rd_op,
  output bfhcv_pkg::qstat_t stat
);

  bfhcv_pkg::op_t   entries [bfhcv_pkg::QDEPTH];
  bfhcv_pkg::qptr_t wr_ptr;
  bfhcv_pkg::qptr_t rd_ptr;
  bfhcv_pkg::qcnt_t count;

  assign rd_op      = entries[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == bfhcv_pkg::qcnt_t'(bfhcv_pkg::QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bfhcv_pkg::qptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bfhcv_pkg::qptr_t'(1);
      end
      if (push && !pop) begin
        count <= count + bfhcv_pkg::qcnt_t'(1);
      end else if (pop && !push) begin
        count <= count - bfhcv_pkg::qcnt_t'(1);
      end
    end
  end

endmodule

// File: rtl/bfhcv_back.sv
// back end: event state, flash selection, nearest hit search and result register
// depends on bfhcv_pkg
module bfhcv_back (
  input  logic              clk,
  input  logic              rst,
  input  bfhcv_pkg::cfg_t   cfg,
  input  bfhcv_pkg::op_t    op,
  input  logic              op_valid,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output bfhcv_pkg::res_t   res
);

  logic                      flash_found;
  logic signed [27:0]        best_time;
  logic [19:0]               best_pe;
  bfhcv_pkg::count_t         passing_count;
  logic [32:0]               nearest_abs;
  logic signed [32:0]        nearest_dt;
  logic signed [32:0]        nearest_time;
  logic                      match_latched;
  logic [19:0]               match_pe;
  logic signed [20:0]        match_x;
  logic signed [20:0]        match_y;
  logic signed [20:0]        match_z;
  bfhcv_pkg::count_t         hit_count;

  logic signed [33:0]        dt;
  logic [33:0]               adt;
  logic                      nearer;
  logic                      in_window;

  // an end request needs the result register free
  assign pop = op_valid &&
               (op.kind != bfhcv_pkg::KIND_END || !res_valid || res_ready);

  assign dt        = 34'(best_time) - 34'(op.rel_time);
  assign adt       = dt[33] ? 34'(-dt) : 34'(dt);
  assign nearer    = adt < {1'b0, nearest_abs};
  assign in_window = adt < 34'(cfg.resolution_ns);

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_found   <= 1'b0;
      best_time     <= bfhcv_pkg::NO_FLASH_TIME;
      best_pe       <= '0;
      passing_count <= '0;
      nearest_abs   <= bfhcv_pkg::START_ABS_DT;
      nearest_dt    <= '0;
      nearest_time  <= '0;
      match_latched <= 1'b0;
      match_pe      <= '0;
      match_x       <= '0;
      match_y       <= '0;
      match_z       <= '0;
      hit_count     <= '0;
      res_valid     <= 1'b0;
      res           <= '0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        case (op.kind)
          bfhcv_pkg::KIND_START: begin
            flash_found   <= 1'b0;
            best_time     <= bfhcv_pkg::NO_FLASH_TIME;
            best_pe       <= '0;
            passing_count <= '0;
            nearest_abs   <= bfhcv_pkg::START_ABS_DT;
            nearest_dt    <= '0;
            nearest_time  <= '0;
            match_latched <= 1'b0;
            match_pe      <= '0;
            match_x       <= '0;
            match_y       <= '0;
            match_z       <= '0;
            hit_count     <= '0;
          end
          bfhcv_pkg::KIND_FLASH: begin
            if (op.flash_ok) begin
              if (passing_count != '1) begin
                passing_count <= passing_count + bfhcv_pkg::count_t'(1);
              end
              // first of equally bright flashes wins
              if (!flash_found || op.pe > best_pe) begin
                flash_found <= 1'b1;
                best_time   <= op.flash_time;
                best_pe     <= op.pe;
              end
            end
          end
          bfhcv_pkg::KIND_HIT: begin
            if (hit_count != '1) begin
              hit_count <= hit_count + bfhcv_pkg::count_t'(1);
            end
            if (op.hit_en && !match_latched && nearer) begin
              nearest_abs  <= adt[32:0];
              nearest_dt   <= dt[32:0];
              nearest_time <= op.rel_time;
              if (in_window) begin
                match_latched <= 1'b1;
                match_pe      <= op.pe;
                match_x       <= op.pos_x;
                match_y       <= op.pos_y;
                match_z       <= op.pos_z;
              end
            end
          end
          bfhcv_pkg::KIND_END: begin
            res_valid                 <= 1'b1;
            res.pass_event            <= !(cfg.use_as_filter && match_latched);
            res.coinc_match           <= match_latched;
            res.flashes_passing       <= 16'(passing_count);
            res.best_flash_time       <= best_time;
            res.best_flash_pe         <= best_pe;
            res.closest_dt            <= nearest_dt;
            res.closest_hit_time      <= nearest_time;
            res.matched_pe            <= match_pe;
            res.matched_x             <= match_x;
            res.matched_y             <= match_y;
            res.matched_z             <= match_z;
            res.hits_seen             <= 16'(hit_count);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/beam_flash_hit_coincidence_veto.sv
// beam flash / detector hit coincidence veto: config registers, front, queue, back
// an end request passes a queue entry; the back end then registers its result
// throughput: one request per cycle; input stalls only once the 4-entry queue fills,
// which happens when an end request waits on a held result and further requests follow
// reset: sync active-high rst clears config (planes all on), event state, queue, output valid
// depends on bfhcv_pkg, bfhcv_front, bfhcv_queue, bfhcv_back, assert_macros.svh
`include "assert_macros.svh"

module beam_flash_hit_coincidence_veto (
  input  logic         clk,
  input  logic         rst,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // time_value[30:0], pe_value[50:31], plane[52:51], pos_x[73:53], pos_y[94:74],
  // pos_z[115:95], zero pad[119:116]
  input  logic [119:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pass_event[0], coinc_match[1], flashes_passing[17:2], best_flash_time[45:18],
  // best_flash_pe[65:46], closest_dt[98:66], closest_hit_time[131:99],
  // matched_pe[151:132], matched_x[172:152], matched_y[193:173], matched_z[214:194],
  // hits_seen[230:215], zero pad[231]
  output logic [231:0] m_axis_tdata,
  // configuration write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [27:0]  cfg_data
);

  bfhcv_pkg::cfg_t   cfg;
  bfhcv_pkg::op_t    fe_op;
  bfhcv_pkg::op_t    be_op;
  bfhcv_pkg::qstat_t q_stat;
  bfhcv_pkg::res_t   res;
  logic              q_push;
  logic              q_pop;

  // configuration registers; user must write only while the block is idle, block does not check
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{plane_enable: 4'hf, default: '0};
    end else if (cfg_we) begin
      case (bfhcv_pkg::reg_idx_t'(cfg_index))
        bfhcv_pkg::REG_BEAM_START:    cfg.beam_start_ns <= cfg_data;
        bfhcv_pkg::REG_BEAM_END:      cfg.beam_end_ns   <= cfg_data;
        bfhcv_pkg::REG_PE_MIN:        cfg.pe_min        <= cfg_data[19:0];
        bfhcv_pkg::REG_DT_OFFSET:     cfg.dt_offset_ns  <= cfg_data;
        bfhcv_pkg::REG_RESOLUTION:    cfg.resolution_ns <= cfg_data[26:0];
        bfhcv_pkg::REG_USE_AS_FILTER: cfg.use_as_filter <= cfg_data[0];
        bfhcv_pkg::REG_PLANE_ENABLE:  cfg.plane_enable  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // front: takes each request, keeps event gps time, precomputes flash and hit tests
  bfhcv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_user  (s_axis_tuser),
    .s_data  (s_axis_tdata),
    .s_ready (s_axis_tready),
    .cfg     (cfg),
    .qstat   (q_stat),
    .push    (q_push),
    .op      (fe_op)
  );

  // queue decouples request intake from result backpressure
  bfhcv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wr_op (fe_op),
    .pop   (q_pop),
    .rd_op (be_op),
    .stat  (q_stat)
  );

  // back: per-event state update, one request per cycle while no end request waits on the result
  bfhcv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op        (be_op),
    .op_valid  (!q_stat.empty),
    .pop       (q_pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {1'b0, res.hits_seen, res.matched_z, res.matched_y, res.matched_x,
                         res.matched_pe, res.closest_hit_time, res.closest_dt,
                         res.best_flash_pe, res.best_flash_time, res.flashes_passing,
                         res.coinc_match, res.pass_event};

  // no match means the matched-hit fields are cleared
  `ASSERT_IMPLY(a_nomatch_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[1], ~|m_axis_tdata[214:132])
  // a full queue takes no request
  `ASSERT_IMPLY(a_q_full, clk, rst, q_stat.full, !q_push)
  // nothing leaves right after reset
  `ASSERT_PROP(a_out_after_reset, clk, rst, $past(rst) |-> !m_axis_tvalid)

endmodule
